[hdl/ssb_pkg.sv]
// ----------------------------------------------------------------------------
// ssb_pkg
// Shared types and reset values for the sporadic server budget unit.
// ----------------------------------------------------------------------------
package ssb_pkg;

  localparam int unsigned RingDepthDefault = 8;

  localparam logic [31:0] InitialBudgetRst   = 32'd1000;
  localparam logic [31:0] ReplenishPeriodRst = 32'd10000;
  localparam logic [3:0]  MaxPendingRst      = 4'd8;
  localparam logic [8:0]  LowPriorityRst     = 9'h1FF;
  localparam logic [7:0]  NormalPriorityRst  = 8'd1;

  typedef enum logic [2:0] {
    REG_INITIAL_BUDGET   = 3'd0,
    REG_REPLENISH_PERIOD = 3'd1,
    REG_MAX_PENDING      = 3'd2,
    REG_LOW_PRIORITY     = 3'd3,
    REG_NORMAL_PRIORITY  = 3'd4
  } reg_index_e;

  typedef enum logic [1:0] {
    KIND_START   = 2'd0,
    KIND_STOP    = 2'd1,
    KIND_TICK    = 2'd2,
    KIND_RESTART = 2'd3
  } kind_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DROP,
    ST_CHARGE,
    ST_RF_RD,
    ST_RF_CHK,
    ST_RF_END,
    ST_EVENT,
    ST_STOP_ABS,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    PH_DROP,
    PH_PRE,
    PH_POST
  } phase_e;

  typedef struct packed {
    logic [63:0] date;
    logic [31:0] amount;
  } refill_t;

  function automatic logic reached(logic [63:0] now, logic [63:0] date);
    logic [63:0] diff;
    diff = now - date;
    return ~diff[63];
  endfunction

endpackage

[hdl/ssb_ring_ram.sv]
// ----------------------------------------------------------------------------
// ssb_ring_ram
// Replenishment ring storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
module ssb_ring_ram #(
  parameter int unsigned RING_DEPTH = ssb_pkg::RingDepthDefault,
  localparam int unsigned IW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [IW-1:0]    waddr_i,
  input  ssb_pkg::refill_t wdata_i,
  input  logic [IW-1:0]    raddr_i,
  output ssb_pkg::refill_t rdata_o
);

  ssb_pkg::refill_t mem [RING_DEPTH];
  ssb_pkg::refill_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/sporadic_server_budget_unit.sv]
// ----------------------------------------------------------------------------
// sporadic_server_budget_unit
// Budget keeper for one sporadic-server task with a replenishment ring.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                 | payload
//  in      | input     | in_valid_i / in_ready_o   | kind_i, now_i
//  out     | output    | out_valid_o / out_ready_i | budget_left_o .. charge_refused_o
//  cfg     | input     | cfg_we_i (no wait)        | cfg_index_i, cfg_wdata_i
//
// An event runs the drop check, a refill walk, the event step and a second
// refill walk before it is done; a refill walk reads the ring once per entry inspected.
// One event is worked at a time; a new request is taken while a result waits.
// The ring needs no clearing after reset: fill count and indexes guard it.
// A stalled result holds the sequencer in its final step until taken.
module sporadic_server_budget_unit #(
  parameter int unsigned RING_DEPTH = ssb_pkg::RingDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  kind_i,
  input  logic [63:0] now_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] budget_left_o,
  output logic [7:0]  current_priority_o,
  output logic        held_o,
  output logic        is_running_o,
  output logic [3:0]  pending_count_o,
  output logic        drop_armed_o,
  output logic [63:0] drop_date_o,
  output logic [63:0] next_refill_date_o,
  output logic        dropped_o,
  output logic        refilled_o,
  output logic        charge_refused_o
);

  localparam int unsigned IW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int unsigned PW = $clog2(RING_DEPTH + 1);
  localparam int unsigned CW = (PW > 4) ? PW : 4;
  localparam logic [IW-1:0] LastIdx = IW'(RING_DEPTH - 1);
  localparam logic [CW-1:0] DepthC  = CW'(RING_DEPTH);

  // configuration
  logic [31:0] init_q, period_q;
  logic [3:0]  maxp_q;
  logic [8:0]  lowp_q;
  logic [7:0]  normp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_q   <= ssb_pkg::InitialBudgetRst;
      period_q <= ssb_pkg::ReplenishPeriodRst;
      maxp_q   <= ssb_pkg::MaxPendingRst;
      lowp_q   <= ssb_pkg::LowPriorityRst;
      normp_q  <= ssb_pkg::NormalPriorityRst;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        ssb_pkg::REG_INITIAL_BUDGET:   init_q   <= cfg_wdata_i;
        ssb_pkg::REG_REPLENISH_PERIOD: period_q <= cfg_wdata_i;
        ssb_pkg::REG_MAX_PENDING:      maxp_q   <= cfg_wdata_i[3:0];
        ssb_pkg::REG_LOW_PRIORITY:     lowp_q   <= cfg_wdata_i[8:0];
        ssb_pkg::REG_NORMAL_PRIORITY:  normp_q  <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  ssb_pkg::state_e state_q, state_d;
  ssb_pkg::phase_e phase_q, phase_d;

  logic [1:0]    kind_q, kind_d;
  logic [63:0]   now_q, now_d;
  logic [31:0]   budget_q, budget_d;
  logic [63:0]   resume_q, resume_d;
  logic [63:0]   deadline_q, deadline_d;
  logic          da_q, da_d, run_q, run_d, bg_q, bg_d, hold_q, hold_d;
  logic [IW-1:0] wr_idx_q, wr_idx_d, rd_idx_q, rd_idx_d;
  logic [PW-1:0] pend_q, pend_d;
  logic [63:0]   amt_q, amt_d;
  logic          hit_q, hit_d, drp_q, drp_d, rfl_q, rfl_d, ref_q, ref_d;
  logic          ov_q, ov_d, load_out;

  logic             ram_we;
  ssb_pkg::refill_t ram_wdata, ram_rdata;

  ssb_ring_ram #(.RING_DEPTH(RING_DEPTH)) u_ring (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(wr_idx_q),
    .wdata_i(ram_wdata),
    .raddr_i(rd_idx_q),
    .rdata_o(ram_rdata)
  );

  logic [CW-1:0] pend_ext, maxp_ext, limit;
  logic [32:0]   sum;
  logic [31:0]   charge;
  logic          prio_above;

  assign pend_ext   = CW'(pend_q);
  assign maxp_ext   = CW'(maxp_q);
  assign limit      = (maxp_ext > DepthC) ? DepthC : maxp_ext;
  assign sum        = {1'b0, budget_q} + {1'b0, ram_rdata.amount};
  assign charge     = (amt_q > {32'd0, budget_q}) ? budget_q : amt_q[31:0];
  assign prio_above = $signed({2'b00, normp_q}) > $signed({lowp_q[8], lowp_q});

  always_comb begin
    state_d    = state_q;
    phase_d    = phase_q;
    kind_d     = kind_q;
    now_d      = now_q;
    budget_d   = budget_q;
    resume_d   = resume_q;
    deadline_d = deadline_q;
    da_d       = da_q;
    run_d      = run_q;
    bg_d       = bg_q;
    hold_d     = hold_q;
    wr_idx_d   = wr_idx_q;
    rd_idx_d   = rd_idx_q;
    pend_d     = pend_q;
    amt_d      = amt_q;
    hit_d      = hit_q;
    drp_d      = drp_q;
    rfl_d      = rfl_q;
    ref_d      = ref_q;
    ov_d       = ov_q;
    load_out   = 1'b0;
    ram_we     = 1'b0;
    ram_wdata  = '{date: resume_q + {32'd0, period_q}, amount: charge};
    in_ready_o = (state_q == ssb_pkg::ST_IDLE);

    if (ov_q && out_ready_i) ov_d = 1'b0;

    unique case (state_q)
      ssb_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          kind_d  = kind_i;
          now_d   = now_i;
          hit_d   = 1'b0;
          drp_d   = 1'b0;
          rfl_d   = 1'b0;
          ref_d   = 1'b0;
          state_d = ssb_pkg::ST_DROP;
        end
      end
      ssb_pkg::ST_DROP: begin
        if (da_q && ssb_pkg::reached(now_q, deadline_q)) begin
          drp_d   = 1'b1;
          da_d    = 1'b0;
          amt_d   = {32'd0, budget_q};
          phase_d = ssb_pkg::PH_DROP;
          state_d = ssb_pkg::ST_CHARGE;
        end else begin
          phase_d = ssb_pkg::PH_PRE;
          state_d = ssb_pkg::ST_RF_RD;
        end
      end
      ssb_pkg::ST_CHARGE: begin
        if (pend_ext >= limit) begin
          ref_d = 1'b1;
        end else begin
          budget_d = budget_q - charge;
          ram_we   = 1'b1;
          wr_idx_d = (wr_idx_q == LastIdx) ? '0 : wr_idx_q + 1'b1;
          pend_d   = pend_q + 1'b1;
        end
        state_d = ssb_pkg::ST_RF_RD;
      end
      ssb_pkg::ST_RF_RD: begin
        // wait for the ring read at the current read index
        state_d = ssb_pkg::ST_RF_CHK;
      end
      ssb_pkg::ST_RF_CHK: begin
        if (pend_q != '0 && ssb_pkg::reached(now_q, ram_rdata.date)) begin
          budget_d = (sum > {1'b0, init_q}) ? init_q : sum[31:0];
          rd_idx_d = (rd_idx_q == LastIdx) ? '0 : rd_idx_q + 1'b1;
          pend_d   = pend_q - 1'b1;
          hit_d    = 1'b1;
          state_d  = ssb_pkg::ST_RF_RD;
        end else begin
          state_d = ssb_pkg::ST_RF_END;
        end
      end
      ssb_pkg::ST_RF_END: begin
        logic b_nz;
        b_nz  = (budget_q != '0);
        hit_d = 1'b0;
        if (hit_q) begin
          rfl_d = 1'b1;
          if (b_nz) begin
            if (hold_q) hold_d = 1'b0;
            else        bg_d   = 1'b0;
            if (run_q) begin
              resume_d   = now_q;
              deadline_d = now_q + {32'd0, budget_q};
              da_d       = 1'b1;
            end
          end
        end
        unique case (phase_q)
          ssb_pkg::PH_DROP: begin
            // budget after refill decides whether to demote or hold
            if (!(hit_q && b_nz) && !b_nz && !(hit_q ? 1'b0 : bg_q) && !bg_q &&
                prio_above) begin
              if (lowp_q[8]) begin
                if (!hold_q) begin
                  hold_d = 1'b1;
                  run_d  = 1'b0;
                  da_d   = 1'b0;
                end
              end else begin
                bg_d = 1'b1;
              end
            end
            phase_d = ssb_pkg::PH_PRE;
            state_d = ssb_pkg::ST_RF_RD;
          end
          ssb_pkg::PH_PRE:  state_d = ssb_pkg::ST_EVENT;
          default:          state_d = ssb_pkg::ST_DONE;
        endcase
      end
      ssb_pkg::ST_EVENT: begin
        phase_d = ssb_pkg::PH_POST;
        state_d = ssb_pkg::ST_RF_RD;
        amt_d   = now_q - resume_q;
        unique case (kind_q)
          ssb_pkg::KIND_START: begin
            if (!run_q && !hold_q) begin
              run_d = 1'b1;
              if (budget_q != '0) begin
                resume_d   = now_q;
                deadline_d = now_q + {32'd0, budget_q};
                da_d       = 1'b1;
              end
            end
          end
          ssb_pkg::KIND_STOP: begin
            if (run_q) begin
              run_d = 1'b0;
              if (budget_q != '0) begin
                da_d    = 1'b0;
                state_d = ssb_pkg::ST_STOP_ABS;
              end
            end
          end
          ssb_pkg::KIND_RESTART: begin
            budget_d = init_q;
            wr_idx_d = '0;
            rd_idx_d = '0;
            pend_d   = '0;
            bg_d     = 1'b0;
            hold_d   = 1'b0;
            if (run_q && init_q != '0) begin
              resume_d   = now_q;
              deadline_d = now_q + {32'd0, init_q};
              da_d       = 1'b1;
            end else begin
              da_d = 1'b0;
            end
          end
          default: ;
        endcase
      end
      ssb_pkg::ST_STOP_ABS: begin
        amt_d   = amt_q[63] ? (64'd0 - amt_q) : amt_q;
        state_d = ssb_pkg::ST_CHARGE;
      end
      ssb_pkg::ST_DONE: begin
        // hold until the output register is free
        if (!ov_q || out_ready_i) begin
          load_out = 1'b1;
          ov_d     = 1'b1;
          state_d  = ssb_pkg::ST_IDLE;
        end
      end
      default: state_d = ssb_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ssb_pkg::ST_IDLE;
      phase_q    <= ssb_pkg::PH_PRE;
      budget_q   <= ssb_pkg::InitialBudgetRst;
      resume_q   <= '0;
      deadline_q <= '0;
      da_q       <= 1'b0;
      run_q      <= 1'b0;
      bg_q       <= 1'b0;
      hold_q     <= 1'b0;
      wr_idx_q   <= '0;
      rd_idx_q   <= '0;
      pend_q     <= '0;
      hit_q      <= 1'b0;
      drp_q      <= 1'b0;
      rfl_q      <= 1'b0;
      ref_q      <= 1'b0;
      ov_q       <= 1'b0;
    end else begin
      state_q    <= state_d;
      phase_q    <= phase_d;
      budget_q   <= budget_d;
      resume_q   <= resume_d;
      deadline_q <= deadline_d;
      da_q       <= da_d;
      run_q      <= run_d;
      bg_q       <= bg_d;
      hold_q     <= hold_d;
      wr_idx_q   <= wr_idx_d;
      rd_idx_q   <= rd_idx_d;
      pend_q     <= pend_d;
      hit_q      <= hit_d;
      drp_q      <= drp_d;
      rfl_q      <= rfl_d;
      ref_q      <= ref_d;
      ov_q       <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    now_q  <= now_d;
    amt_q  <= amt_d;
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      budget_left_o      <= budget_q;
      current_priority_o <= bg_q ? lowp_q[7:0] : normp_q;
      held_o             <= hold_q;
      is_running_o       <= run_q;
      pending_count_o    <= pend_ext[3:0];
      drop_armed_o       <= da_q;
      drop_date_o        <= deadline_q;
      next_refill_date_o <= (pend_q != '0) ? ram_rdata.date : 64'd0;
      dropped_o          <= drp_q;
      refilled_o         <= rfl_q;
      charge_refused_o   <= ref_q;
    end
  end

  assign out_valid_o = ov_q;

endmodule

[hdl/ssb_checker.sv]
// ----------------------------------------------------------------------------
// ssb_checker
// Port-level checks on the sporadic server budget unit results.
// ----------------------------------------------------------------------------
module ssb_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        held_o,
  input logic        is_running_o,
  input logic        drop_armed_o,
  input logic [31:0] budget_left_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_held_not_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && held_o |-> !is_running_o)
    else $error("held task reported running");

  a_held_unarmed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && held_o |-> !drop_armed_o)
    else $error("held task with armed deadline");

  a_held_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && held_o |-> budget_left_o == 32'd0)
    else $error("held task with budget left");

endmodule

bind sporadic_server_budget_unit ssb_checker u_ssb_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .held_o       (held_o),
  .is_running_o (is_running_o),
  .drop_armed_o (drop_armed_o),
  .budget_left_o(budget_left_o)
);
